FILE: hdl/lpwu_pkg.sv
// Shared constants and helpers for the linear predictor weight unit.
`default_nettype none
package lpwu_pkg;
    localparam int MaxWeights = 64;
    localparam int MaxHistory = 256;
    localparam int MaxNodes   = 256;
    localparam int WAW = $clog2(MaxWeights);
    localparam int HAW = $clog2(MaxHistory);
    localparam int NAW = $clog2(MaxNodes);
    localparam logic signed [31:0] InitTenth = 32'sd1677722;

    localparam logic [2:0] ACT_LINK    = 3'd0;
    localparam logic [2:0] ACT_NODE    = 3'd1;
    localparam logic [2:0] ACT_PREDICT = 3'd2;
    localparam logic [2:0] ACT_UPDATE  = 3'd3;
    localparam logic [2:0] ACT_INIT    = 3'd4;

    localparam logic CFG_WEIGHTS = 1'b0;
    localparam logic CFG_HISTORY = 1'b1;

    // Saturate a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // Q8.24 product scaled by 2^-24 with truncation toward zero.
    function automatic logic signed [39:0] qscale(input logic signed [63:0] p);
        logic signed [63:0] a;
        a = p + ((p < 0) ? 64'sh0000_0000_00FF_FFFF : 64'sd0);
        return a[63:24];
    endfunction
endpackage
`default_nettype wire

FILE: hdl/lpwu_div.sv
// Serial signed divider: alpha_delta divided by a small positive divisor.
`default_nettype none
module lpwu_div import lpwu_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire signed [31:0] i_num,
    input  wire        [6:0]  i_den,
    output logic              o_done,
    output logic signed [31:0] o_quot
);
    logic [31:0] r_q, n_q;
    logic [6:0]  r_rem, n_rem;
    logic [6:0]  r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [7:0]  w_trial;
    always_comb begin
        w_trial = {r_rem, r_q[31]};
        n_q = {r_q[30:0], 1'b0};
        n_rem = w_trial[6:0];
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = 7'(w_trial - {1'b0, r_den});
            n_q[0] = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[31];
                r_q    <= i_num[31] ? 32'(-i_num) : i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

FILE: hdl/linear_predictor_weight_update.sv
// Top level of the linear predictor weight unit.
`default_nettype none
// One request is taken at a time. Link writes, node writes and spare codes go
// straight to the result. Predict passes every prediction weight one at a time
// through the link memory, the node memory and one multiply-accumulate. Update
// first runs a serial divide for the step and then walks the weights the same
// way, writing each back to the weight memory. Init clears the history memory
// one entry a cycle, together with the weights in use and the bias. Counts
// above the table sizes are read as the table sizes. After reset a pass loads
// 0.1 into the history and weight memories; no request is taken during it.
// Each request returns exactly one result; a finished result is held in an
// output register while the next request is already accepted, and the unit
// waits at the end of that next request until the held result has been taken.
module linear_predictor_weight_update import lpwu_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [8:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], slot[8:3], node_index[16:9], node_value[48:17],
    // history_index[56:49], alpha_delta[88:57], zero fill [95:89]
    input  wire  [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // weighted_total[31:0]
    output logic [31:0] m_axis_tdata,
    // sum_valid[0]
    output logic [0:0]  m_axis_tuser
);
    localparam logic [2:0] ST_CLEAR = 3'd0, ST_IDLE = 3'd1, ST_DIV = 3'd2,
                           ST_WALK = 3'd3, ST_INIT = 3'd4, ST_DONE = 3'd5;

    logic [2:0] r_state;
    logic [6:0] r_wcount;
    logic [8:0] r_hcount;

    // Decoded request fields.
    logic [2:0]  w_act;
    logic [5:0]  w_slot;
    logic [7:0]  w_node;
    logic [31:0] w_nval;
    logic [7:0]  w_hidx;
    logic [31:0] w_ad;
    assign w_act  = s_axis_tdata[2:0];
    assign w_slot = s_axis_tdata[8:3];
    assign w_node = s_axis_tdata[16:9];
    assign w_nval = s_axis_tdata[48:17];
    assign w_hidx = s_axis_tdata[56:49];
    assign w_ad   = s_axis_tdata[88:57];

    logic [2:0]  r_act;
    logic [7:0]  r_hidx;
    logic signed [31:0] r_step;
    logic [6:0]  w_n;
    logic [8:0]  w_h;
    assign w_n = (r_wcount > 7'(MaxWeights)) ? 7'(MaxWeights) : r_wcount;
    assign w_h = (r_hcount > 9'(MaxHistory)) ? 9'(MaxHistory) : r_hcount;

    // Memories.
    logic [7:0]  m_link [MaxWeights];
    logic [31:0] m_node [MaxNodes];
    logic [31:0] m_pred [MaxWeights];
    logic [31:0] m_hist [MaxHistory];
    logic signed [31:0] r_bias;

    // Walk pipeline: stage 0 reads link and weight, 1 reads node value,
    // 2 multiplies, 3 accumulates or writes back.
    logic [7:0] r_cnt;
    logic [3:0] r_v;
    logic [WAW-1:0] r_a1, r_a2, r_a3;
    logic [7:0]  r_link_q;
    logic signed [31:0] r_pred_q, r_pred2, r_pred3, r_node_q, r_hist_q;
    logic signed [63:0] r_prod;
    logic signed [47:0] r_acc;
    logic w_walk_end;

    // The result is written out only once the output register is free.
    logic w_done_go;
    assign w_done_go = (r_state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

    logic w_div_start, w_div_done;
    logic signed [31:0] w_quot;
    lpwu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_ad), .i_den(7'(w_n + 7'd2)), .o_done(w_div_done), .o_quot(w_quot)
    );

    logic w_take;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_take = s_axis_tvalid && s_axis_tready;
    assign w_div_start = w_take && (w_act == ACT_UPDATE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcount <= '0;
            r_hcount <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WEIGHTS: r_wcount <= i_cfg_data[6:0];
                CFG_HISTORY: r_hcount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_walk_end = (r_cnt >= {1'b0, w_n}) && (r_v == 4'd0);

    logic signed [39:0] w_term;
    assign w_term = qscale(r_prod);

    always_ff @(posedge i_clk) begin
        // Memory reads, registered.
        r_link_q <= m_link[r_cnt[WAW-1:0]];
        r_pred_q <= m_pred[r_cnt[WAW-1:0]];
        r_node_q <= m_node[r_link_q];
        r_hist_q <= m_hist[r_hidx];
        r_pred2  <= r_pred_q;
        r_pred3  <= r_pred2;
        r_a2 <= r_a1; r_a3 <= r_a2;
        r_a1 <= r_cnt[WAW-1:0];
        if (r_act == ACT_PREDICT)
            r_prod <= 64'(r_pred2) * 64'(r_node_q);
        else
            r_prod <= 64'(r_step) * 64'(r_node_q);
        if (w_take && w_act == ACT_LINK && {2'b0, w_slot} < 8'(MaxWeights))
            m_link[w_slot[WAW-1:0]] <= w_node;
        if (w_take && w_act == ACT_NODE && {1'b0, w_node} < 9'(MaxNodes))
            m_node[w_node[NAW-1:0]] <= w_nval;
        if (r_state == ST_CLEAR) begin
            m_hist[r_cnt] <= InitTenth;
            if (r_cnt < 8'(MaxWeights)) m_pred[r_cnt[WAW-1:0]] <= InitTenth;
        end else if (r_state == ST_INIT) begin
            if ({1'b0, r_cnt} < r_hcount) m_hist[r_cnt] <= '0;
            if (r_cnt < {1'b0, w_n}) m_pred[r_cnt[WAW-1:0]] <= '0;
        end else if (r_state == ST_WALK && r_act == ACT_UPDATE && r_v[2]) begin
            m_pred[r_a3] <= sat32(48'(r_pred3) + 48'(w_term));
        end
        if (w_done_go && r_act == ACT_UPDATE)
            m_hist[r_hidx] <= sat32(48'(r_hist_q) + 48'(r_step));
    end

    // Control state machine and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_v     <= '0;
            r_bias  <= InitTenth;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && !w_done_go) m_axis_tvalid <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'(MaxHistory - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: if (w_take) begin
                    r_act  <= w_act;
                    r_hidx <= w_hidx;
                    r_cnt  <= '0;
                    r_v    <= '0;
                    r_acc  <= 48'(r_bias);
                    case (w_act)
                        ACT_UPDATE:  r_state <= ST_DIV;
                        ACT_PREDICT: r_state <= ST_WALK;
                        ACT_INIT:    r_state <= ST_INIT;
                        default:     r_state <= ST_DONE;
                    endcase
                end
                ST_DIV: if (w_div_done) begin
                    r_step  <= w_quot;
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    r_v <= {r_v[2:0], r_cnt < {1'b0, w_n}};
                    if (r_cnt < {1'b0, w_n}) r_cnt <= r_cnt + 8'd1;
                    if (r_v[2] && r_act == ACT_PREDICT)
                        r_acc <= r_acc + 48'(w_term);
                    if (r_cnt >= {1'b0, w_n} && r_v[2:0] == 3'd0 && !r_v[3]
                        || w_walk_end)
                        r_state <= ST_DONE;
                end
                ST_INIT: begin
                    r_cnt <= r_cnt + 8'd1;
                    r_bias <= '0;
                    // The last cycle covers both the history and the weight range.
                    if (({1'b0, r_cnt} + 9'd1 >= w_h) &&
                        ({1'b0, r_cnt} + 9'd1 >= {2'b0, w_n}))
                        r_state <= ST_DONE;
                end
                ST_DONE: if (w_done_go) begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tuser  <= (r_act == ACT_PREDICT);
                    if (r_act == ACT_PREDICT)
                        m_axis_tdata <= sat32(r_acc + 48'(r_hist_q));
                    else
                        m_axis_tdata <= '0;
                    if (r_act == ACT_UPDATE)
                        r_bias <= sat32(48'(r_bias) + 48'(r_step));
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/lpwu_checker.sv
// Port-level checker for the linear predictor weight unit, with its bind.
`default_nettype none
module lpwu_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [0:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("non-sum result carries data");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("two requests in flight");
endmodule
bind linear_predictor_weight_update lpwu_checker u_chk (.*);
`default_nettype wire
